[rtl/substring_first_match_core_defines.svh]
// ----------------------------------------------------------------------------
// substring first match assertion macros
// shared property wrappers, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_FIRST_MATCH_CORE_DEFINES_SVH
`define SUBSTRING_FIRST_MATCH_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SFM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SFM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/sfm_pkg.sv]
// ----------------------------------------------------------------------------
// sfm_pkg
// shared types and constants of the substring first match core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfm_pkg;

   // default pattern capacity
   localparam int SFM_MAX_PATTERN = 64;

   // field widths
   localparam int DATA_W   = 8;
   localparam int MODE_W   = 2;
   localparam int POS_W    = 32;
   localparam int STATUS_W = 2;
   localparam int TEXT_W   = 31;
   localparam int RSP_TDATA_W = ((POS_W + STATUS_W + 7) / 8) * 8;

   // text count at which further text words set the overflow flag
   localparam logic [TEXT_W-1:0] TEXT_LIMIT = {TEXT_W{1'b1}};

   // item kinds carried on tuser
   typedef enum logic [MODE_W-1:0] {
      MODE_PATTERN = 2'd0,
      MODE_TEXT    = 2'd1,
      MODE_FINISH  = 2'd2
   } mode_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_PAT_LONG  = 2'd1,
      STATUS_TEXT_LONG = 2'd2
   } status_type;

   // controls broadcast from the top to every cell
   typedef struct packed {
      logic              clear;
      logic              load;
      logic              step;
      logic [DATA_W-1:0] data_byte;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[rtl/sfm_cell.sv]
// ----------------------------------------------------------------------------
// sfm_cell
// one pattern position: holds its pattern byte and its partial-match bit,
// and hands the match bit on to the next position every text word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfm_cell #(
   parameter int MAX_PATTERN = sfm_pkg::SFM_MAX_PATTERN,
   parameter int INDEX       = 0
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire sfm_pkg::cell_ctrl_type          ctrl,
   input  wire [$clog2(MAX_PATTERN + 1)-1:0]    pat_len,
   input  wire                                  prev_match,
   output logic                                 match,
   output logic                                 hit
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam logic [LEN_W-1:0] MY_INDEX = LEN_W'(INDEX);
   localparam logic [LEN_W-1:0] MY_COUNT = LEN_W'(INDEX + 1);

   logic [sfm_pkg::DATA_W-1:0] pat_byte_ff;
   logic                       match_ff;
   logic                       match_in;
   logic                       active;
   logic                       is_last;

   // position lies inside the stored pattern
   assign active  = pat_len > MY_INDEX;
   assign is_last = pat_len == MY_COUNT;

   // new partial-match bit from the neighbor's old bit
   assign match_in = prev_match && active && (pat_byte_ff == ctrl.data_byte);

   // pattern byte, written when this is the next free position
   always_ff @(posedge clock) begin
      if (ctrl.load && (pat_len == MY_INDEX)) begin
         pat_byte_ff <= ctrl.data_byte;
      end
   end

   // partial-match bit
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         match_ff <= 1'b0;
      end else if (ctrl.step) begin
         match_ff <= match_in;
      end
   end

   assign match = match_ff;
   assign hit   = is_last && match_in;

endmodule

`default_nettype wire

[rtl/substring_first_match_core.sv]
// ----------------------------------------------------------------------------
// substring_first_match_core
// first position of a pattern in a byte stream, one cell per pattern byte
// ----------------------------------------------------------------------------
// usage:
//   req channel: tuser carries the item kind (pattern byte, text byte,
//   finish), tdata the byte. pattern words come first, then text words.
//   every text word is compared against all stored pattern bytes at once
//   in the cell row, so one word is taken each cycle.
//   a finish word puts one result word on the rsp channel in the cycle
//   after it is taken and clears the block; the next pattern may follow
//   in the very next cycle.
//   rsp word: position (first match start, 0 for an empty pattern, all ones
//   when not found) and a status code (pattern too long, text too long).
//   throughput: one word per cycle while no finish word waits on a held result.
//   when the receiver stalls, the result stays in the output register;
//   pattern and text words keep flowing, only a further finish word waits.
//   reset (synchronous, active high) empties the pattern and all flags;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "substring_first_match_core_defines.svh"

module substring_first_match_core #(
   parameter int MAX_PATTERN = sfm_pkg::SFM_MAX_PATTERN
) (
   input  wire                                clock,
   input  wire                                reset,
   // request stream
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire [sfm_pkg::DATA_W-1:0]          req_tdata,   // [7:0] data_byte
   input  wire [sfm_pkg::MODE_W-1:0]          req_tuser,   // [1:0] mode
   // response stream
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [sfm_pkg::RSP_TDATA_W-1:0]    rsp_tdata    // [31:0] position,
                                                           // [33:32] status
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_PATTERN);
   localparam int TW = sfm_pkg::TEXT_W;

   logic [LEN_W-1:0] pat_len_ff, pat_len_in;
   logic [TW-1:0]    text_cnt_ff, text_cnt_in;
   logic [TW-1:0]    found_pos_ff, found_pos_in;
   logic             found_ff, found_in;
   logic             pat_ovf_ff, pat_ovf_in;
   logic             text_ovf_ff, text_ovf_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [sfm_pkg::POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [sfm_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   sfm_pkg::mode_type      mode;
   sfm_pkg::cell_ctrl_type ctrl;
   logic                   req_accept;
   logic                   rsp_free;
   logic                   text_seen;
   logic                   finish_acc;
   logic                   hit_any;
   logic [MAX_PATTERN-1:0] match_vec;
   logic [MAX_PATTERN-1:0] hit_vec;

   assign mode       = sfm_pkg::mode_type'(req_tuser);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = rsp_free || (mode != sfm_pkg::MODE_FINISH);
   assign req_accept = req_tvalid && req_tready;
   assign text_seen  = (text_cnt_ff != '0) || text_ovf_ff;
   assign hit_any    = |hit_vec;

   // decode the accepted word into cell controls and counter updates
   always_comb begin
      ctrl.clear     = 1'b0;
      ctrl.load      = 1'b0;
      ctrl.step      = 1'b0;
      ctrl.data_byte = req_tdata;
      finish_acc     = 1'b0;
      pat_len_in     = pat_len_ff;
      text_cnt_in    = text_cnt_ff;
      found_in       = found_ff;
      found_pos_in   = found_pos_ff;
      pat_ovf_in     = pat_ovf_ff;
      text_ovf_in    = text_ovf_ff;
      if (req_accept) begin
         case (mode)
            sfm_pkg::MODE_PATTERN: begin
               if (!text_seen) begin
                  if (pat_len_ff == LEN_FULL) begin
                     pat_ovf_in = 1'b1;
                  end else begin
                     ctrl.load  = 1'b1;
                     pat_len_in = pat_len_ff + LEN_W'(1);
                  end
               end
            end
            sfm_pkg::MODE_TEXT: begin
               if (text_cnt_ff == sfm_pkg::TEXT_LIMIT) begin
                  text_ovf_in = 1'b1;
               end else begin
                  ctrl.step   = 1'b1;
                  text_cnt_in = text_cnt_ff + TW'(1);
                  if (hit_any && !found_ff) begin
                     found_in     = 1'b1;
                     found_pos_in = text_cnt_ff - TW'(pat_len_ff) + TW'(1);
                  end
               end
            end
            sfm_pkg::MODE_FINISH: begin
               finish_acc   = 1'b1;
               ctrl.clear   = 1'b1;
               pat_len_in   = '0;
               text_cnt_in  = '0;
               found_in     = 1'b0;
               found_pos_in = '0;
               pat_ovf_in   = 1'b0;
               text_ovf_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // row of pattern cells, each match bit feeds the next cell
   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      logic prev;
      if (i == 0) begin : g_head
         assign prev = 1'b1;
      end else begin : g_link
         assign prev = match_vec[i-1];
      end
      sfm_cell #(
         .MAX_PATTERN (MAX_PATTERN),
         .INDEX       (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .pat_len    (pat_len_ff),
         .prev_match (prev),
         .match      (match_vec[i]),
         .hit        (hit_vec[i])
      );
   end

   // result word built from the state before the clear
   always_comb begin
      if (pat_len_ff == '0) begin
         rsp_pos_in = '0;
      end else if (found_ff) begin
         rsp_pos_in = {1'b0, found_pos_ff};
      end else begin
         rsp_pos_in = '1;
      end
      if (pat_ovf_ff) begin
         rsp_status_in = sfm_pkg::STATUS_PAT_LONG;
      end else if (text_ovf_ff) begin
         rsp_status_in = sfm_pkg::STATUS_TEXT_LONG;
      end else begin
         rsp_status_in = sfm_pkg::STATUS_OK;
      end
   end

   assign rsp_valid_in = finish_acc || (rsp_valid_ff && !rsp_tready);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff   <= '0;
         text_cnt_ff  <= '0;
         found_ff     <= 1'b0;
         found_pos_ff <= '0;
         pat_ovf_ff   <= 1'b0;
         text_ovf_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pat_len_ff   <= pat_len_in;
         text_cnt_ff  <= text_cnt_in;
         found_ff     <= found_in;
         found_pos_ff <= found_pos_in;
         pat_ovf_ff   <= pat_ovf_in;
         text_ovf_ff  <= text_ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (finish_acc) begin
         rsp_pos_ff    <= rsp_pos_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(sfm_pkg::RSP_TDATA_W - sfm_pkg::POS_W - sfm_pkg::STATUS_W){1'b0}},
                        rsp_status_ff, rsp_pos_ff};

   // checks
   `SFM_ASSERT_NEXT(a_finish_gives_word, finish_acc, rsp_valid_ff, "finish lost its result")
   `SFM_ASSERT_NEXT(a_finish_clears, finish_acc, (pat_len_ff == '0) && !found_ff && !pat_ovf_ff, "finish did not clear")
   `SFM_ASSERT_NOW(a_found_needs_pattern, found_ff, pat_len_ff != '0, "match latched without a pattern")
   `SFM_ASSERT_NOW(a_pat_ovf_full, pat_ovf_ff, pat_len_ff == LEN_FULL, "pattern overflow below capacity")
   `SFM_ASSERT_NOW(a_single_hit, ctrl.step, $countones(hit_vec) <= 1, "more than one last cell hit")

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for substring_first_match_core: a queue-fed driver
// streams pattern, text, finish and unused-kind words with random gaps, a
// monitor tracks a bit-accurate matcher per accepted word and checks every
// result word against the oldest predicted position and status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int PAT_CAP        = sfm_pkg::SFM_MAX_PATTERN;
   localparam int RANDOM_ITEMS   = 650;
   localparam int MIN_FINISHES   = 40;
   localparam int TAIL_ITEMS     = 60;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int DRAIN_CYCLES   = 10;

   // the one item kind that the block must ignore
   localparam logic [sfm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [sfm_pkg::MODE_W-1:0] mode;
      logic [sfm_pkg::DATA_W-1:0] data_byte;
   } stream_word_type;

   typedef struct packed {
      logic [sfm_pkg::POS_W-1:0] position;
      sfm_pkg::status_type       status;
   } match_result_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [sfm_pkg::DATA_W-1:0]      req_tdata  = '0;   // [7:0] data_byte
   logic [sfm_pkg::MODE_W-1:0]      req_tuser  = '0;   // [1:0] mode
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [sfm_pkg::RSP_TDATA_W-1:0] rsp_tdata;   // [31:0] position, [33:32] status

   stream_word_type  pending_words[$];
   match_result_type expected_results[$];

   logic req_fire = 1'b0;
   int   req_gap_left  = 0;
   int   rsp_stall_left = 0;
   int   quiet_cycles  = 0;
   int   mismatch_count = 0;
   int   planned_count = 0;
   int   planned_finishes = 0;

   // matcher state mirrored in the bench
   logic [sfm_pkg::DATA_W-1:0] pat_bytes [PAT_CAP];
   int unsigned                pat_len    = 0;
   logic [PAT_CAP-1:0]         partial    = '0;
   logic [sfm_pkg::TEXT_W-1:0] text_cnt   = '0;
   logic                       found      = 1'b0;
   logic [sfm_pkg::TEXT_W-1:0] found_at   = '0;
   logic                       pat_over   = 1'b0;
   logic                       text_over  = 1'b0;

   substring_first_match_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // advance the mirrored matcher by one accepted word
   task automatic advance_matcher(input logic [sfm_pkg::MODE_W-1:0] mode,
                                  input logic [sfm_pkg::DATA_W-1:0] b);
      match_result_type res;
      case (mode)
         sfm_pkg::MODE_PATTERN: begin
            // pattern words are dropped once text has started
            if (text_cnt == '0 && !text_over) begin
               if (pat_len >= PAT_CAP) begin
                  pat_over = 1'b1;
               end else begin
                  pat_bytes[pat_len] = b;
                  pat_len++;
               end
            end
         end
         sfm_pkg::MODE_TEXT: begin
            if (text_cnt == sfm_pkg::TEXT_LIMIT) begin
               text_over = 1'b1;
            end else begin
               // top bit first so each bit sees the old value below it
               for (int k = PAT_CAP - 1; k >= 0; k--) begin
                  if (k < pat_len) begin
                     if (k == 0) begin
                        partial[k] = (pat_bytes[k] == b);
                     end else begin
                        partial[k] = partial[k-1] && (pat_bytes[k] == b);
                     end
                  end
               end
               if (pat_len > 0 && !found && partial[pat_len-1]) begin
                  found    = 1'b1;
                  found_at = text_cnt - sfm_pkg::TEXT_W'(pat_len - 1);
               end
               text_cnt++;
            end
         end
         sfm_pkg::MODE_FINISH: begin
            if (pat_len == 0) begin
               res.position = '0;
            end else if (found) begin
               res.position = {1'b0, found_at};
            end else begin
               res.position = '1;
            end
            if (pat_over) begin
               res.status = sfm_pkg::STATUS_PAT_LONG;
            end else if (text_over) begin
               res.status = sfm_pkg::STATUS_TEXT_LONG;
            end else begin
               res.status = sfm_pkg::STATUS_OK;
            end
            expected_results.push_back(res);
            pat_len   = 0;
            partial   = '0;
            text_cnt  = '0;
            found     = 1'b0;
            found_at  = '0;
            pat_over  = 1'b0;
            text_over = 1'b0;
         end
         default: begin
            // unused kind leaves the block untouched
         end
      endcase
   endtask

   task automatic queue_word(input logic [sfm_pkg::MODE_W-1:0] mode,
                             input logic [sfm_pkg::DATA_W-1:0] b);
      stream_word_type w;
      w.mode      = mode;
      w.data_byte = b;
      pending_words.push_back(w);
      planned_count++;
      if (mode == sfm_pkg::MODE_FINISH) planned_finishes++;
   endtask

   // request driver, fed from the pending queue
   always @(negedge clock) begin
      stream_word_type nxt_word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap_left > 0) begin
            req_gap_left = req_gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (pending_words.size() >= TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
            req_gap_left = $urandom_range(1, 4) - 1;
            req_tvalid <= 1'b0;
         end else begin
            nxt_word = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= nxt_word.mode;
            req_tdata  <= nxt_word.data_byte;
         end
      end
   end

   // response back-pressure in short bursts, none near the end
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (pending_words.size() < TAIL_ITEMS) begin
         rsp_tready <= 1'b1;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left = rsp_stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(1, 4) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: check result words, then track accepted request words
   always @(posedge clock) begin
      match_result_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result word with nothing expected: position %0d status %0d",
                      $signed(rsp_tdata[sfm_pkg::POS_W-1:0]),
                      rsp_tdata[sfm_pkg::POS_W +: sfm_pkg::STATUS_W]);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[sfm_pkg::POS_W-1:0] !== want.position) begin
                  $error("position: expected %0d actual %0d",
                         $signed(want.position), $signed(rsp_tdata[sfm_pkg::POS_W-1:0]));
                  mismatch_count++;
               end
               if (rsp_tdata[sfm_pkg::POS_W +: sfm_pkg::STATUS_W] !== want.status) begin
                  $error("status: expected %0d actual %0d",
                         want.status, rsp_tdata[sfm_pkg::POS_W +: sfm_pkg::STATUS_W]);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) advance_matcher(req_tuser, req_tdata);
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic [sfm_pkg::DATA_W-1:0] symbols [3];
      logic [sfm_pkg::DATA_W-1:0] pat_copy [PAT_CAP + 4];
      int kind;
      int n_sym;
      int plen;
      int tlen;
      int insert_at;
      int n_noise;
      bit embed;

      // empty pattern, finish back to back
      queue_word(sfm_pkg::MODE_FINISH, 8'h00);
      queue_word(sfm_pkg::MODE_FINISH, 8'hFF);
      // extremes of the byte, match found early and held
      queue_word(sfm_pkg::MODE_PATTERN, 8'h00);
      queue_word(sfm_pkg::MODE_PATTERN, 8'hFF);
      queue_word(sfm_pkg::MODE_TEXT, 8'hFF);
      queue_word(sfm_pkg::MODE_TEXT, 8'h00);
      queue_word(sfm_pkg::MODE_TEXT, 8'hFF);
      queue_word(sfm_pkg::MODE_TEXT, 8'h00);
      queue_word(sfm_pkg::MODE_TEXT, 8'hFF);
      queue_word(sfm_pkg::MODE_FINISH, 8'h00);
      // no match, unused kind in between
      queue_word(sfm_pkg::MODE_PATTERN, 8'h5A);
      queue_word(sfm_pkg::MODE_TEXT, 8'hA5);
      queue_word(MODE_UNUSED, 8'h5A);
      queue_word(sfm_pkg::MODE_TEXT, 8'h11);
      queue_word(sfm_pkg::MODE_FINISH, 8'hFF);
      // pattern word after text is dropped
      queue_word(sfm_pkg::MODE_PATTERN, 8'h41);
      queue_word(sfm_pkg::MODE_TEXT, 8'h42);
      queue_word(sfm_pkg::MODE_PATTERN, 8'h43);
      queue_word(sfm_pkg::MODE_TEXT, 8'h41);
      queue_word(sfm_pkg::MODE_FINISH, 8'h00);
      // text with an empty pattern
      queue_word(sfm_pkg::MODE_TEXT, 8'h7F);
      queue_word(sfm_pkg::MODE_FINISH, 8'h80);

      while (planned_count < RANDOM_ITEMS || planned_finishes < MIN_FINISHES) begin
         kind = $urandom_range(0, 19);
         for (int i = 0; i < 3; i++) symbols[i] = sfm_pkg::DATA_W'($urandom_range(0, 255));
         n_sym = $urandom_range(1, 3);
         if (kind == 0) begin
            // overlong pattern, text may hold the truncated part
            plen = PAT_CAP + $urandom_range(1, 4);
            for (int i = 0; i < plen; i++) begin
               pat_copy[i] = symbols[$urandom_range(0, n_sym - 1)];
               queue_word(sfm_pkg::MODE_PATTERN, pat_copy[i]);
            end
            tlen = $urandom_range(0, 4);
            for (int i = 0; i < tlen; i++) begin
               queue_word(sfm_pkg::MODE_TEXT, symbols[$urandom_range(0, n_sym - 1)]);
            end
            if ($urandom_range(0, 1) == 1) begin
               for (int i = 0; i < PAT_CAP; i++) queue_word(sfm_pkg::MODE_TEXT, pat_copy[i]);
            end
            queue_word(sfm_pkg::MODE_FINISH, sfm_pkg::DATA_W'($urandom_range(0, 255)));
         end else if (kind < 4) begin
            // noise of every kind, broken sequences included
            n_noise = $urandom_range(1, 8);
            for (int i = 0; i < n_noise; i++) begin
               queue_word(sfm_pkg::MODE_W'($urandom_range(0, 3)),
                          sfm_pkg::DATA_W'($urandom_range(0, 255)));
            end
         end else begin
            // well-formed: pattern, text over the same few symbols, finish
            if ($urandom_range(0, 9) == 0) begin
               plen = $urandom_range(7, PAT_CAP);
            end else begin
               plen = $urandom_range(0, 6);
            end
            for (int i = 0; i < plen; i++) begin
               pat_copy[i] = symbols[$urandom_range(0, n_sym - 1)];
               queue_word(sfm_pkg::MODE_PATTERN, pat_copy[i]);
            end
            tlen      = $urandom_range(0, 16);
            embed     = (plen > 0) && ($urandom_range(0, 1) == 1);
            insert_at = $urandom_range(0, tlen);
            for (int i = 0; i <= tlen; i++) begin
               if (embed && i == insert_at) begin
                  for (int j = 0; j < plen; j++) queue_word(sfm_pkg::MODE_TEXT, pat_copy[j]);
               end
               if (i < tlen) begin
                  queue_word(sfm_pkg::MODE_TEXT, symbols[$urandom_range(0, n_sym - 1)]);
               end
            end
            queue_word(sfm_pkg::MODE_FINISH, sfm_pkg::DATA_W'($urandom_range(0, 255)));
         end
      end
      queue_word(sfm_pkg::MODE_FINISH, 8'h00);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_tvalid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
